@@ sv/arc_pkg.sv @@
// ----------------------------------------------------------------------------
// ADC reading calibrator package
// Shared widths, limits, status codes and pipeline depths.
// ----------------------------------------------------------------------------
package arc_pkg;

    localparam int CODE_BITS    = 12;
    localparam int EXT_CHANNELS = 4;
    localparam int CFG_REGS     = 3;
    localparam int CFG_IDX_W    = 2;

    // 3300 mV times 100 (hundredths of a millivolt).
    localparam int CAL_SCALE    = 330000;
    localparam int CAL_SCALE_W  = 19;

    localparam int K_W   = CODE_BITS + CAL_SCALE_W;
    localparam int NUM_W = CODE_BITS + K_W + 1;
    localparam int DEN_W = 2 * CODE_BITS;
    localparam int Q_W   = 21;
    localparam int CMP_W = DEN_W + Q_W + 1;

    localparam int TD_W = 2 * CODE_BITS + 2;
    localparam int TN_W = 2 * CODE_BITS + 16;

    localparam int LANE_STAGES = Q_W + 1;
    localparam int LANES       = EXT_CHANNELS + 4;

    localparam logic [Q_W-1:0] VOLT_MAX   = Q_W'(1000000);
    localparam logic [Q_W-1:0] VBAT_MAX   = Q_W'(2000000);
    localparam logic [Q_W-1:0] TEMP_LIMIT = Q_W'(1000000);

    localparam logic [CODE_BITS-1:0] FULL_SCALE = {CODE_BITS{1'b1}};

    localparam logic [CODE_BITS-1:0] VREF_CAL_RESET = CODE_BITS'(1520);
    localparam logic [CODE_BITS-1:0] TEMP_LOW_RESET = CODE_BITS'(940);
    localparam logic [CODE_BITS-1:0] TEMP_HIGH_RESET = CODE_BITS'(1200);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_VREF_CAL  = 2'd0,
        REG_TEMP_LOW  = 2'd1,
        REG_TEMP_HIGH = 2'd2
    } cfg_index_t;

    typedef enum logic [1:0] {
        STATUS_OK        = 2'd0,
        STATUS_VREF_ZERO = 2'd1,
        STATUS_SPAN_ZERO = 2'd2
    } status_t;

endpackage

@@ sv/arc_div_lane.sv @@
// ----------------------------------------------------------------------------
// ADC calibrator divider lane
// Pipelined restoring divider, one quotient bit per stage, saturating.
// ----------------------------------------------------------------------------
module arc_div_lane (
    input  logic                      clk,
    input  logic [arc_pkg::LANE_STAGES-1:0] load,
    input  logic [arc_pkg::NUM_W-1:0] num,
    input  logic [arc_pkg::DEN_W-1:0] den,
    input  logic [arc_pkg::Q_W-1:0]   limit,
    output logic [arc_pkg::Q_W-1:0]   quot
);
    import arc_pkg::*;

    logic [NUM_W-1:0] rem_reg [LANE_STAGES];
    logic [Q_W-1:0]   quo_reg [LANE_STAGES];
    logic [DEN_W-1:0] den_reg [LANE_STAGES];
    logic [Q_W-1:0]   lim_reg [LANE_STAGES];
    logic             ovf_reg [LANE_STAGES];

    // Entry stage: a quotient that needs more than Q_W bits is flagged here.
    always_ff @(posedge clk)
    begin
        if (load[0])
        begin
            rem_reg[0] <= num;
            quo_reg[0] <= '0;
            den_reg[0] <= den;
            lim_reg[0] <= limit;
            ovf_reg[0] <= CMP_W'(num) >= (CMP_W'(den) << Q_W);
        end
    end

    for (genvar j = 1; j < LANE_STAGES; j++)
    begin : g_step
        localparam int BIT = Q_W - j;
        logic [CMP_W-1:0] trial;
        logic             take;

        assign trial = CMP_W'(den_reg[j-1]) << BIT;
        assign take  = CMP_W'(rem_reg[j-1]) >= trial;

        always_ff @(posedge clk)
        begin
            if (load[j])
            begin
                rem_reg[j] <= take ? NUM_W'(CMP_W'(rem_reg[j-1]) - trial) : rem_reg[j-1];
                quo_reg[j] <= quo_reg[j-1] | (take ? (Q_W'(1) << BIT) : '0);
                den_reg[j] <= den_reg[j-1];
                lim_reg[j] <= lim_reg[j-1];
                ovf_reg[j] <= ovf_reg[j-1];
            end
        end
    end

    always_comb
    begin
        if (ovf_reg[LANE_STAGES-1] || quo_reg[LANE_STAGES-1] > lim_reg[LANE_STAGES-1])
        begin
            quot = lim_reg[LANE_STAGES-1];
        end
        else
        begin
            quot = quo_reg[LANE_STAGES-1];
        end
    end

endmodule

@@ sv/adc_reading_calibrator_unit.sv @@
// ----------------------------------------------------------------------------
// ADC reading calibrator
// Turns one scan set of raw ADC codes into supply, channel, reference and
// battery voltages in hundredths of a millivolt and die temperature in
// hundredths of a degree, with a status code.
// ----------------------------------------------------------------------------
// Throughput: one scan set per cycle while the output is not stalled; eight
// divider lanes of 22 stages each, an entry stage and then one quotient bit
// per stage, set the depth.
// Stages hold their data when the next one is full, so bubbles close up and
// input is taken while a finished result waits at the output register.
// Reset clears all valid flags and loads the calibration registers with their
// factory defaults; the data path registers are not reset.
module adc_reading_calibrator_unit (
    input  logic clk,
    input  logic rst_n,

    input  logic                               cfg_wr_en,
    input  logic [arc_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [arc_pkg::CODE_BITS-1:0]      cfg_data,

    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [arc_pkg::CODE_BITS-1:0]      ext_code_0,
    input  logic [arc_pkg::CODE_BITS-1:0]      ext_code_1,
    input  logic [arc_pkg::CODE_BITS-1:0]      ext_code_2,
    input  logic [arc_pkg::CODE_BITS-1:0]      ext_code_3,
    input  logic [arc_pkg::CODE_BITS-1:0]      temp_code,
    input  logic [arc_pkg::CODE_BITS-1:0]      vref_code,
    input  logic [arc_pkg::CODE_BITS-1:0]      vbat_code,

    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [19:0]                        supply_centi_mv,
    output logic [19:0]                        ext_centi_mv_0,
    output logic [19:0]                        ext_centi_mv_1,
    output logic [19:0]                        ext_centi_mv_2,
    output logic [19:0]                        ext_centi_mv_3,
    output logic [19:0]                        vref_centi_mv,
    output logic signed [20:0]                 temp_centi_c,
    output logic [20:0]                        vbat_centi_mv,
    output logic [1:0]                         status
);
    import arc_pkg::*;

    // Pipeline positions: input, products, numerators, divider lanes, output.
    localparam int NST     = LANE_STAGES + 4;
    localparam int LANE_LO = 3;
    localparam int OUT_ST  = NST - 1;

    localparam int L_SUPPLY = 0;
    localparam int L_VREF   = EXT_CHANNELS + 1;
    localparam int L_VBAT   = EXT_CHANNELS + 2;
    localparam int L_TEMP   = EXT_CHANNELS + 3;

    localparam logic signed [TN_W-1:0] TEMP_LOW_CENTI  = TN_W'(3000);
    localparam logic signed [TN_W-1:0] TEMP_SPAN_CENTI = TN_W'(8000);

    // ------------------------------------------------------------------
    // Calibration registers.
    // ------------------------------------------------------------------
    logic [CODE_BITS-1:0] vref_cal_reg;
    logic [CODE_BITS-1:0] temp_low_reg;
    logic [CODE_BITS-1:0] temp_high_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vref_cal_reg  <= VREF_CAL_RESET;
            temp_low_reg  <= TEMP_LOW_RESET;
            temp_high_reg <= TEMP_HIGH_RESET;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                REG_VREF_CAL:  vref_cal_reg  <= cfg_data;
                REG_TEMP_LOW:  temp_low_reg  <= cfg_data;
                REG_TEMP_HIGH: temp_high_reg <= cfg_data;
                default:       ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Flow control. Each stage moves forward when the next one is empty
    // or is itself moving, so a stalled output only blocks full stages.
    // ------------------------------------------------------------------
    logic [NST-1:0] valid_reg;
    logic [NST-1:0] valid_next;
    logic [NST-1:0] free;
    logic [NST-1:0] leaving;
    logic [NST-1:0] load;

    always_comb
    begin
        free[OUT_ST]    = !valid_reg[OUT_ST] || out_ready;
        leaving[OUT_ST] = valid_reg[OUT_ST] && out_ready;
        for (int i = OUT_ST - 1; i >= 0; i--)
        begin
            free[i]    = !valid_reg[i] || free[i+1];
            leaving[i] = valid_reg[i] && free[i+1];
        end
        load[0] = in_valid && free[0];
        for (int i = 1; i < NST; i++)
        begin
            load[i] = leaving[i-1];
        end
        valid_next = load | (valid_reg & ~leaving);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign in_ready  = free[0];
    assign out_valid = valid_reg[OUT_ST];

    // ------------------------------------------------------------------
    // Stage 0: capture the scan set.
    // ------------------------------------------------------------------
    logic [CODE_BITS-1:0] s0_ext_reg [EXT_CHANNELS];
    logic [CODE_BITS-1:0] s0_temp_reg;
    logic [CODE_BITS-1:0] s0_vref_reg;
    logic [CODE_BITS-1:0] s0_vbat_reg;

    always_ff @(posedge clk)
    begin
        if (load[0])
        begin
            s0_ext_reg[0] <= ext_code_0;
            s0_ext_reg[1] <= ext_code_1;
            s0_ext_reg[2] <= ext_code_2;
            s0_ext_reg[3] <= ext_code_3;
            s0_temp_reg   <= temp_code;
            s0_vref_reg   <= vref_code;
            s0_vbat_reg   <= vbat_code;
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: first products and the status decision. The reference code
    // is checked before the calibration span.
    // ------------------------------------------------------------------
    logic signed [CODE_BITS:0] span;
    status_t                   s1_status_next;

    assign span = $signed({1'b0, temp_high_reg}) - $signed({1'b0, temp_low_reg});

    always_comb
    begin
        priority if (s0_vref_reg == '0)
        begin
            s1_status_next = STATUS_VREF_ZERO;
        end
        else if (span == '0)
        begin
            s1_status_next = STATUS_SPAN_ZERO;
        end
        else
        begin
            s1_status_next = STATUS_OK;
        end
    end

    logic [K_W-1:0]          s1_k_reg;
    logic [DEN_W-1:0]        s1_vfs_reg;
    logic signed [TD_W-1:0]  s1_tden_reg;
    logic [DEN_W-1:0]        s1_tc_reg;
    logic [DEN_W-1:0]        s1_lv_reg;
    logic [CODE_BITS-1:0]    s1_ext_reg [EXT_CHANNELS];
    logic [CODE_BITS-1:0]    s1_vref_reg;
    logic [CODE_BITS-1:0]    s1_vbat_reg;
    status_t                 s1_status_reg;

    always_ff @(posedge clk)
    begin
        if (load[1])
        begin
            s1_k_reg      <= K_W'(vref_cal_reg) * K_W'(CAL_SCALE);
            s1_vfs_reg    <= DEN_W'(s0_vref_reg) * DEN_W'(FULL_SCALE);
            s1_tden_reg   <= TD_W'($signed({1'b0, s0_vref_reg})) * TD_W'(span);
            s1_tc_reg     <= DEN_W'(s0_temp_reg) * DEN_W'(vref_cal_reg);
            s1_lv_reg     <= DEN_W'(temp_low_reg) * DEN_W'(s0_vref_reg);
            s1_ext_reg    <= s0_ext_reg;
            s1_vref_reg   <= s0_vref_reg;
            s1_vbat_reg   <= s0_vbat_reg;
            s1_status_reg <= s1_status_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: numerators. Channel numerators are code times the scale
    // word; the battery one carries the factor of two from the bridge.
    // ------------------------------------------------------------------
    logic signed [DEN_W:0]  tdiff;
    logic signed [TN_W-1:0] tnum_next;

    assign tdiff     = $signed({1'b0, s1_tc_reg}) - $signed({1'b0, s1_lv_reg});
    assign tnum_next = TEMP_LOW_CENTI * TN_W'(s1_tden_reg)
                     + TEMP_SPAN_CENTI * TN_W'(tdiff);

    logic [NUM_W-1:0]       s2_num_reg [LANES];
    logic [DEN_W-1:0]       s2_vfs_reg;
    logic [CODE_BITS-1:0]   s2_vref_reg;
    logic signed [TN_W-1:0] s2_tnum_reg;
    logic signed [TD_W-1:0] s2_tden_reg;
    status_t                s2_status_reg;

    always_ff @(posedge clk)
    begin
        if (load[2])
        begin
            s2_num_reg[L_SUPPLY] <= NUM_W'(s1_k_reg);
            for (int k = 0; k < EXT_CHANNELS; k++)
            begin
                s2_num_reg[1+k] <= NUM_W'(s1_ext_reg[k]) * NUM_W'(s1_k_reg);
            end
            s2_num_reg[L_VREF] <= NUM_W'(s1_vref_reg) * NUM_W'(s1_k_reg);
            s2_num_reg[L_VBAT] <= (NUM_W'(s1_vbat_reg) * NUM_W'(s1_k_reg)) << 1;
            s2_num_reg[L_TEMP] <= '0;
            s2_vfs_reg    <= s1_vfs_reg;
            s2_vref_reg   <= s1_vref_reg;
            s2_tnum_reg   <= tnum_next;
            s2_tden_reg   <= s1_tden_reg;
            s2_status_reg <= s1_status_reg;
        end
    end

    // ------------------------------------------------------------------
    // Divider lanes. Temperature divides magnitudes and restores the sign
    // at the end, which truncates toward zero.
    // ------------------------------------------------------------------
    logic [TN_W-1:0]  tnum_mag;
    logic [TD_W-1:0]  tden_mag;
    logic             temp_neg;

    assign tnum_mag = s2_tnum_reg[TN_W-1] ? TN_W'(-s2_tnum_reg) : TN_W'(s2_tnum_reg);
    assign tden_mag = s2_tden_reg[TD_W-1] ? TD_W'(-s2_tden_reg) : TD_W'(s2_tden_reg);
    assign temp_neg = s2_tnum_reg[TN_W-1] ^ s2_tden_reg[TD_W-1];

    logic [NUM_W-1:0] lane_num [LANES];
    logic [DEN_W-1:0] lane_den [LANES];
    logic [Q_W-1:0]   lane_lim [LANES];
    logic [Q_W-1:0]   lane_q   [LANES];

    always_comb
    begin
        for (int l = 0; l < LANES; l++)
        begin
            lane_num[l] = s2_num_reg[l];
            lane_den[l] = s2_vfs_reg;
            lane_lim[l] = VOLT_MAX;
        end
        lane_den[L_SUPPLY] = DEN_W'(s2_vref_reg);
        lane_lim[L_VBAT]   = VBAT_MAX;
        lane_num[L_TEMP]   = NUM_W'(tnum_mag);
        lane_den[L_TEMP]   = DEN_W'(tden_mag);
        lane_lim[L_TEMP]   = TEMP_LIMIT;
    end

    for (genvar l = 0; l < LANES; l++)
    begin : g_lane
        arc_div_lane u_lane (
            .clk   (clk),
            .load  (load[LANE_LO +: LANE_STAGES]),
            .num   (lane_num[l]),
            .den   (lane_den[l]),
            .limit (lane_lim[l]),
            .quot  (lane_q[l])
        );
    end

    // Status and temperature sign travel beside the lanes.
    status_t side_status_reg [LANE_STAGES];
    logic    side_neg_reg    [LANE_STAGES];

    always_ff @(posedge clk)
    begin
        if (load[LANE_LO])
        begin
            side_status_reg[0] <= s2_status_reg;
            side_neg_reg[0]    <= temp_neg;
        end
        for (int j = 1; j < LANE_STAGES; j++)
        begin
            if (load[LANE_LO+j])
            begin
                side_status_reg[j] <= side_status_reg[j-1];
                side_neg_reg[j]    <= side_neg_reg[j-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // Output register: merge lane results. Any error status zeroes every
    // value field of the transaction.
    // ------------------------------------------------------------------
    logic                   err;
    logic [Q_W:0]           temp_signed;

    assign err         = side_status_reg[LANE_STAGES-1] != STATUS_OK;
    assign temp_signed = side_neg_reg[LANE_STAGES-1] ? ((Q_W+1)'(0) - {1'b0, lane_q[L_TEMP]})
                                                     : {1'b0, lane_q[L_TEMP]};

    always_ff @(posedge clk)
    begin
        if (load[OUT_ST])
        begin
            supply_centi_mv <= err ? '0 : lane_q[L_SUPPLY][19:0];
            ext_centi_mv_0  <= err ? '0 : lane_q[1][19:0];
            ext_centi_mv_1  <= err ? '0 : lane_q[2][19:0];
            ext_centi_mv_2  <= err ? '0 : lane_q[3][19:0];
            ext_centi_mv_3  <= err ? '0 : lane_q[4][19:0];
            vref_centi_mv   <= err ? '0 : lane_q[L_VREF][19:0];
            temp_centi_c    <= err ? '0 : $signed(temp_signed[20:0]);
            vbat_centi_mv   <= err ? '0 : lane_q[L_VBAT][20:0];
            status          <= side_status_reg[LANE_STAGES-1];
        end
    end

endmodule
